/* hw/rtl/heightmap_normal_generator_core_macros.svh */
// Assertion macros for the height-map normal generator.
// Taken in by every RTL file that carries concurrent checks; needs clk and rst_n in scope.
`ifndef HEIGHTMAP_NORMAL_GENERATOR_CORE_MACROS_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// The expression must hold at every clock edge outside reset.
`define HNG_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("hng invariant violated");
// The consequent must hold in the same cycle as the antecedent.
`define HNG_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hng implication violated");
`else
`define HNG_ASSERT_ALWAYS(label, expr)
`define HNG_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

/* hw/rtl/hng_pkg.sv */
// Shared constants, types and helper functions of the height-map normal generator.
// No dependencies; imported by hng_ram and the top level.
package hng_pkg;

  localparam int HNG_MAX_WIDTH = 1024;
  localparam int HSTEP         = 5;
  localparam int SAMPLE_W      = 8;
  localparam int MAPW_W        = 11;
  localparam int MAPH_W        = 16;
  localparam int NORM_W        = 16;
  localparam int SUM_W         = 14;  // |5 * sum of four height differences| <= 5100
  localparam int MAG_W         = 13;
  localparam int SQ_W          = 26;  // sum of squares stays below 2^26
  localparam int QUO_W         = 31;  // floor(2^30 * a^2 / sq) <= 2^30
  localparam int NLANE         = 3;

  typedef enum logic {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic top;
    logic down;
    logic left;
    logic right;
  } quad_t;

  function automatic logic signed [10:0] hng_diff(input logic [SAMPLE_W-1:0] p,
                                                  input logic [SAMPLE_W-1:0] q);
    hng_diff = $signed({3'b000, p}) - $signed({3'b000, q});
  endfunction

endpackage

/* hw/rtl/heightmap_normal_generator_core.sv */
// Height-map to normal-map generator, top level.
// Depends on hng_pkg, hng_ram and heightmap_normal_generator_core_macros.svh.
//
// Height samples of a map_width x map_height map arrive in raster order, one per input beat
// with in_mode low. Two line stores (RAMs of MAX_WIDTH bytes) hold the previous two rows and a
// 3x3 window of registers follows the scan. For every pixel the face normals of the up to four
// triangles around it are summed and the sum is normalised to a unit vector in signed Q1.14,
// rounded to nearest with ties away from zero. Results lag by one row plus one pixel; after the
// last sample of a map, map_width+1 drain beats (in_mode high) release the pixels still held.
// A drain beat with nothing due gives no result. A sample beat while drains are due drops them.
// A configuration write restarts the map; write only while the block is idle.
// Flow: a beat that yields a normal occupies the block through one line-store read, three
// arithmetic stages (sums, squares, sum of squares), a restoring divider and a digit-by-digit
// square root, run in three lanes at once, then the output load. A beat that yields no normal
// only takes the line-store read; a drain beat with nothing due is taken without leaving idle.
// The finished normal sits in an output register, so the next beat is taken while it waits.

`include "heightmap_normal_generator_core_macros.svh"

module heightmap_normal_generator_core import hng_pkg::*; #(
  parameter int MAX_WIDTH = HNG_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [MAPH_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [SAMPLE_W-1:0]      in_height_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NORM_W-1:0] out_normal_x,
  output logic signed [NORM_W-1:0] out_normal_y,
  output logic signed [NORM_W-1:0] out_normal_z,
  output logic                     out_last_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);      // line-store address
  localparam int WW = $clog2(MAX_WIDTH + 1);  // column position up to the width itself
  localparam int WX = WW + 1;
  localparam int PW = $clog2(MAX_WIDTH + 2);  // drain count up to width plus one

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SUM, S_SQ, S_LOAD, S_DIV, S_ROOT, S_DONE
  } state_t;

  state_t                   state_r;
  logic [MAPW_W-1:0]        map_width_r;
  logic [MAPH_W-1:0]        map_height_r;
  logic [CW-1:0]            col_r;
  logic [MAPH_W-1:0]        row_r;
  logic [PW-1:0]            pend_r;
  logic                     mode_r;
  logic [SAMPLE_W-1:0]      samp_r;
  logic                     use_ram_r;
  logic [CW-1:0]            addr_r;
  logic [WW-1:0]            ec_r;
  logic [MAPH_W-1:0]        er_r;
  logic [SAMPLE_W-1:0]      win_r [9];
  quad_t                    quad_r;
  logic                     last_r;
  logic signed [SUM_W-1:0]  s_r [NLANE];
  logic [SQ_W-1:0]          asq_r [NLANE];
  logic [SQ_W-1:0]          sq_r;
  logic                     zero_r;
  logic [SQ_W:0]            rem_r [NLANE];
  logic [QUO_W-1:0]         q_r [NLANE];
  logic [QUO_W-1:0]         res_r [NLANE];
  logic [QUO_W-1:0]         bit_r;
  logic [4:0]               cnt_r;
  logic                     out_valid_r;
  logic signed [NORM_W-1:0] out_n_r [NLANE];
  logic                     out_last_r;

  // Effective map size: width clamped to 1..MAX_WIDTH, a height of zero counts as one.
  logic [WW-1:0]     eff_w;
  logic [MAPH_W-1:0] eff_h;
  logic [PW-1:0]     w_plus1;

  always_comb begin
    if (map_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(map_width_r) >= MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(map_width_r);
    end
    eff_h   = (map_height_r == '0) ? MAPH_W'(1) : map_height_r;
    w_plus1 = PW'(eff_w) + PW'(1);
  end

  // Acceptance side: where the beat reads the line stores and how the counters move.
  logic          acc;
  logic          drain_ok;
  logic [WW-1:0] vc;
  logic [CW-1:0] c_eff;
  logic [CW-1:0] rd_addr;
  logic [WW-1:0] col_inc;
  logic          col_wrap;
  logic [16:0]   row_inc;
  logic          row_wrap;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    drain_ok = (pend_r != '0) && (pend_r <= w_plus1);
    vc       = WW'(w_plus1 - pend_r);
    c_eff    = (WW'(col_r) >= eff_w) ? '0 : col_r;
    rd_addr  = in_mode ? vc[CW-1:0] : c_eff;
    col_inc  = WW'(c_eff) + WW'(1);
    col_wrap = col_inc >= eff_w;
    row_inc  = {1'b0, row_r} + 17'd1;
    row_wrap = row_inc >= {1'b0, eff_h};
  end

  // Line stores: the two rows above the current row of the scan.
  logic [SAMPLE_W-1:0] bef_rd;
  logic [SAMPLE_W-1:0] mid_rd;
  logic                ls_we;

  assign ls_we = (state_r == S_RD) && !mode_r;

  hng_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row_before (
    .clk  (clk),
    .we   (ls_we),
    .waddr(addr_r),
    .wdata(mid_rd),
    .raddr(rd_addr),
    .rdata(bef_rd)
  );

  hng_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row_middle (
    .clk  (clk),
    .we   (ls_we),
    .waddr(addr_r),
    .wdata(samp_r),
    .raddr(rd_addr),
    .rdata(mid_rd)
  );

  // Which pixel the window centre holds once this column is shifted in, and which of its
  // four quadrants lie inside the map. The first column of a row finishes the last pixel of
  // the row two scan lines back.
  logic          em_ok;
  logic [WW-1:0] cx;
  logic [15:0]   cy;
  quad_t         quad;
  logic          last;

  always_comb begin
    if (ec_r != '0) begin
      em_ok = (er_r != '0);
      cx    = ec_r - WW'(1);
      cy    = er_r - 16'd1;
    end else begin
      em_ok = (er_r >= 16'd2);
      cx    = eff_w - WW'(1);
      cy    = er_r - 16'd2;
    end
    quad.top   = (cy != '0);
    quad.down  = ({1'b0, cy} + 17'd1) < {1'b0, eff_h};
    quad.left  = (cx != '0);
    quad.right = (WX'(cx) + WX'(1)) < WX'(eff_w);
    last       = ((WX'(cx) + WX'(1)) == WX'(eff_w)) && (({1'b0, cy} + 17'd1) == {1'b0, eff_h});
  end

  // Face-normal sums. Window cell index is column * 3 + row, column 0 being the left one;
  // the centre is cell 4. The horizontal step of five scales the height differences.
  logic signed [10:0]      dsx;
  logic signed [10:0]      dsz;
  logic [2:0]              nquad;
  logic signed [SUM_W-1:0] s_nxt [NLANE];

  always_comb begin
    dsx   = '0;
    dsz   = '0;
    nquad = '0;
    if (quad_r.top && quad_r.left) begin
      dsx   = dsx + hng_diff(win_r[4], win_r[1]);
      dsz   = dsz + hng_diff(win_r[1], win_r[0]);
      nquad = nquad + 3'd1;
    end
    if (quad_r.top && quad_r.right) begin
      dsx   = dsx + hng_diff(win_r[6], win_r[3]);
      dsz   = dsz + hng_diff(win_r[4], win_r[3]);
      nquad = nquad + 3'd1;
    end
    if (quad_r.down && quad_r.right) begin
      dsx   = dsx + hng_diff(win_r[7], win_r[4]);
      dsz   = dsz + hng_diff(win_r[8], win_r[7]);
      nquad = nquad + 3'd1;
    end
    if (quad_r.down && quad_r.left) begin
      dsx   = dsx + hng_diff(win_r[5], win_r[2]);
      dsz   = dsz + hng_diff(win_r[5], win_r[4]);
      nquad = nquad + 3'd1;
    end
    s_nxt[0] = SUM_W'(dsx * HSTEP);
    s_nxt[1] = SUM_W'(-(HSTEP * HSTEP) * $signed({1'b0, nquad}));
    s_nxt[2] = SUM_W'(dsz * HSTEP);
  end

  // Per-lane arithmetic. Each component m is the largest integer with
  // (2m-1)^2 * sq <= 2^30 * s^2, which equals (isqrt(floor(2^30 s^2 / sq)) + 1) / 2.
  logic [MAG_W-1:0]       mag      [NLANE];
  logic [SQ_W-1:0]        asq_nxt  [NLANE];
  logic                   div_ge   [NLANE];
  logic [SQ_W:0]          div_sel  [NLANE];
  logic [QUO_W:0]         rt_trial [NLANE];
  logic                   rt_ge    [NLANE];
  logic [16:0]            m17      [NLANE];
  logic signed [NORM_W-1:0] n_nxt  [NLANE];
  logic [SQ_W-1:0]        sq_sum;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag[i]      = MAG_W'(s_r[i][SUM_W-1] ? -s_r[i] : s_r[i]);
      asq_nxt[i]  = SQ_W'(mag[i]) * SQ_W'(mag[i]);
      div_ge[i]   = rem_r[i] >= {1'b0, sq_r};
      div_sel[i]  = div_ge[i] ? (rem_r[i] - {1'b0, sq_r}) : rem_r[i];
      rt_trial[i] = {1'b0, res_r[i]} + {1'b0, bit_r};
      rt_ge[i]    = {1'b0, q_r[i]} >= rt_trial[i];
      m17[i]      = (res_r[i][16:0] + 17'd1) >> 1;
      if (zero_r) begin
        n_nxt[i] = '0;
      end else if (s_r[i][SUM_W-1]) begin
        n_nxt[i] = -$signed(m17[i][NORM_W-1:0]);
      end else begin
        n_nxt[i] = $signed(m17[i][NORM_W-1:0]);
      end
    end
    sq_sum = asq_r[0] + asq_r[1] + asq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_width_r  <= MAPW_W'(1024);
      map_height_r <= MAPH_W'(1024);
      col_r        <= '0;
      row_r        <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            mode_r <= in_mode;
            samp_r <= in_height_sample;
            addr_r <= rd_addr;
            if (in_mode) begin
              if (drain_ok) begin
                use_ram_r <= (vc < eff_w);
                ec_r      <= vc;
                er_r      <= eff_h;
                pend_r    <= pend_r - PW'(1);
                state_r   <= S_RD;
              end else begin
                pend_r <= '0;
              end
            end else begin
              use_ram_r <= 1'b1;
              ec_r      <= WW'(c_eff);
              er_r      <= row_r;
              pend_r    <= '0;
              if (col_wrap) begin
                col_r <= '0;
                if (row_wrap) begin
                  row_r  <= '0;
                  pend_r <= w_plus1;
                end else begin
                  row_r <= row_inc[MAPH_W-1:0];
                end
              end else begin
                col_r <= col_inc[CW-1:0];
              end
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k]     <= win_r[3 + k];
            win_r[3 + k] <= win_r[6 + k];
          end
          win_r[6] <= use_ram_r ? bef_rd : '0;
          win_r[7] <= use_ram_r ? mid_rd : '0;
          win_r[8] <= mode_r ? '0 : samp_r;
          quad_r   <= quad;
          last_r   <= last;
          state_r  <= em_ok ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          for (int i = 0; i < NLANE; i++) begin
            s_r[i] <= s_nxt[i];
          end
          state_r <= S_SQ;
        end
        S_SQ: begin
          for (int i = 0; i < NLANE; i++) begin
            asq_r[i] <= asq_nxt[i];
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          sq_r   <= sq_sum;
          zero_r <= (sq_sum == '0);
          for (int i = 0; i < NLANE; i++) begin
            rem_r[i] <= {1'b0, asq_r[i]};
            q_r[i]   <= '0;
            res_r[i] <= '0;
          end
          bit_r   <= QUO_W'(1) << (QUO_W - 1);
          cnt_r   <= 5'(QUO_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit per cycle, most significant first.
          for (int i = 0; i < NLANE; i++) begin
            rem_r[i] <= {div_sel[i][SQ_W-1:0], 1'b0};
            q_r[i]   <= {q_r[i][QUO_W-2:0], div_ge[i]};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          // Digit-by-digit square root of the quotient, which is consumed in place.
          for (int i = 0; i < NLANE; i++) begin
            if (rt_ge[i]) begin
              q_r[i]   <= q_r[i] - rt_trial[i][QUO_W-1:0];
              res_r[i] <= (res_r[i] >> 1) + bit_r;
            end else begin
              res_r[i] <= res_r[i] >> 1;
            end
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < NLANE; i++) begin
              out_n_r[i] <= n_nxt[i];
            end
            out_last_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_WIDTH: begin
            map_width_r <= cfg_wdata[MAPW_W-1:0];
            col_r       <= '0;
            row_r       <= '0;
            pend_r      <= '0;
          end
          CFG_MAP_HEIGHT: begin
            map_height_r <= cfg_wdata;
            col_r        <= '0;
            row_r        <= '0;
            pend_r       <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_normal_x      = out_n_r[0];
  assign out_normal_y      = out_n_r[1];
  assign out_normal_z      = out_n_r[2];
  assign out_last_of_frame = out_last_r;

  // The drain count never exceeds one more than the width it was loaded for.
  `HNG_ASSERT_ALWAYS(a_pend_bound, pend_r <= w_plus1)
  // The column counter always points inside the current row.
  `HNG_ASSERT_ALWAYS(a_col_bound, WW'(col_r) < eff_w)
  // The divider remainder stays below twice the divisor, so one subtract per step suffices.
  `HNG_ASSERT_IMPLY(a_div_rem, (state_r == S_DIV) && !zero_r, rem_r[0] < {sq_r, 1'b0})

endmodule

/* hw/rtl/hng_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on hng_pkg for default sizes.
module hng_ram import hng_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = HNG_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for heightmap_normal_generator_core: raster maps with random content,
// drain beats, random idling on both channels and several map sizes, checked by a scoreboard.
// Depends on hng_pkg and the RTL of the block; reads no files.
module tb_top;
  import hng_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 6000;  // cycles without any accepted beat before giving up
  localparam int SETTLE      = 70;    // wait for the block to finish beats that give no normal
  localparam int ITEM_GOAL   = 1750;

  typedef struct {
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nz;
    logic              last;
  } normal_t;

  // The scoreboard keeps its own copy of the line stores, window and counters, and computes
  // the normal each accepted beat should produce.
  class normal_board;
    logic [7:0]  row_above [HNG_MAX_WIDTH];
    logic [7:0]  row_mid [HNG_MAX_WIDTH];
    logic [7:0]  win [9];
    int unsigned col, row, drains_due, width_reg, height_reg;
    normal_t     awaited [$];
    int          errors;

    function void clear_all();
      foreach (row_above[i]) begin
        row_above[i] = 0;
        row_mid[i] = 0;
      end
      foreach (win[i]) win[i] = 0;
      col = 0;
      row = 0;
      drains_due = 0;
      width_reg = 1024;
      height_reg = 1024;
      errors = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > HNG_MAX_WIDTH) return HNG_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(cfg_idx_t idx, int unsigned v);
      if (idx == CFG_MAP_WIDTH) width_reg = v & 16'h7FF;
      else height_reg = v & 16'hFFFF;
      col = 0;
      row = 0;
      drains_due = 0;
    endfunction

    function longint win_at(int dx, int dy);
      return longint'(win[(dx + 1) * 3 + (dy + 1)]);
    endfunction

    function void shift_col(logic [7:0] t, logic [7:0] m, logic [7:0] b);
      for (int k = 0; k < 3; k++) begin
        win[k] = win[3 + k];
        win[3 + k] = win[6 + k];
      end
      win[6] = t;
      win[7] = m;
      win[8] = b;
    endfunction

    // Rounded 16384*|s|/sqrt(sq) by bisection on the half-step boundaries.
    function logic [NORM_W-1:0] unit_comp(longint s, longint unsigned sq);
      longint unsigned a, rhs, lo, hi, mid, t;
      if (sq == 0) return '0;
      a = (s < 0) ? -s : s;
      rhs = 4 * 64'd16384 * 64'd16384 * a * a;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * sq <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (s < 0) ? NORM_W'(-lo) : NORM_W'(lo);
    endfunction

    // The window has just taken column (c, r); queue the normal of its centre pixel.
    function void finish_pixel(int unsigned c, int unsigned r);
      int unsigned w, h, cx, cy;
      bit up, dn, lf, rt;
      longint sx, sy, sz, hc, a, b;
      longint unsigned sq;
      normal_t n;
      w = eff_w();
      h = eff_h();
      if (c >= 1) begin
        if (r < 1) return;
        cx = c - 1;
        cy = r - 1;
      end else begin
        if (r < 2) return;
        cx = w - 1;
        cy = r - 2;
      end
      up = cy > 0;
      dn = cy + 1 < h;
      lf = cx > 0;
      rt = cx + 1 < w;
      hc = win_at(0, 0);
      sx = 0;
      sy = 0;
      sz = 0;
      if (up && lf) begin
        a = win_at(-1, 0); b = win_at(-1, -1);
        sx += -HSTEP * (a - hc); sy -= HSTEP * HSTEP; sz += -HSTEP * (b - a);
      end
      if (up && rt) begin
        a = win_at(0, -1); b = win_at(1, -1);
        sx += HSTEP * (b - a); sy -= HSTEP * HSTEP; sz += -HSTEP * (a - hc);
      end
      if (dn && rt) begin
        a = win_at(1, 0); b = win_at(1, 1);
        sx += HSTEP * (a - hc); sy -= HSTEP * HSTEP; sz += HSTEP * (b - a);
      end
      if (dn && lf) begin
        a = win_at(0, 1); b = win_at(-1, 1);
        sx += -HSTEP * (b - a); sy -= HSTEP * HSTEP; sz += HSTEP * (a - hc);
      end
      sq = sx * sx + sy * sy + sz * sz;
      n.nx = unit_comp(sx, sq);
      n.ny = unit_comp(sy, sq);
      n.nz = unit_comp(sz, sq);
      n.last = (cx + 1 == w) && (cy + 1 == h);
      awaited = {awaited, n};
    endfunction

    function void note_beat(logic mode, logic [7:0] hgt);
      int unsigned w, h, c, vc;
      logic [7:0] t, m;
      w = eff_w();
      h = eff_h();
      if (mode) begin
        if (drains_due == 0 || drains_due > w + 1) begin
          drains_due = 0;
          return;
        end
        vc = w + 1 - drains_due;
        if (vc < w) shift_col(row_above[vc], row_mid[vc], 8'd0);
        else shift_col(8'd0, 8'd0, 8'd0);
        drains_due--;
        finish_pixel(vc, h);
      end else begin
        drains_due = 0;
        c = (col >= w) ? 0 : col;
        t = row_above[c];
        m = row_mid[c];
        row_above[c] = m;
        row_mid[c] = hgt;
        shift_col(t, m, hgt);
        finish_pixel(c, row);
        c++;
        if (c >= w) begin
          c = 0;
          row++;
          if (row >= h) begin
            row = 0;
            drains_due = w + 1;
          end
        end
        col = c;
      end
    endfunction

    function void check_beat(logic [NORM_W-1:0] x, logic [NORM_W-1:0] y,
                             logic [NORM_W-1:0] z, logic last);
      normal_t e;
      if (awaited.size() == 0) begin
        $error("normal arrived with none awaited");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (x !== e.nx) begin
        $error("normal_x expected %0d got %0d", $signed(e.nx), $signed(x)); errors++;
      end
      if (y !== e.ny) begin
        $error("normal_y expected %0d got %0d", $signed(e.ny), $signed(y)); errors++;
      end
      if (z !== e.nz) begin
        $error("normal_z expected %0d got %0d", $signed(e.nz), $signed(z)); errors++;
      end
      if (last !== e.last) begin
        $error("last_of_frame expected %0b got %0b", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_MAP_WIDTH;
  logic [MAPH_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [SAMPLE_W-1:0] in_height_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_last_of_frame;

  normal_board board = new();
  int unsigned beats_sent;
  int unsigned normals_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned calm_left;

  heightmap_normal_generator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_height_sample (in_height_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_last_of_frame(out_last_of_frame)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: any accepted beat or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("heightmap_normal_generator_core regression: fail");
        $finish;
      end
    end
  end

  // Offer one input beat. Every call starts and ends just after a rising edge, so valid stays
  // high across back-to-back beats and is only lowered when a gap is drawn.
  task automatic send_beat(logic mode, logic [7:0] hgt);
    int unsigned gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_height_sample <= hgt;
    do @(posedge clk); while (!in_ready);
    board.note_beat(mode, hgt);
    beats_sent++;
  endtask

  // Wait for every awaited normal, then for the block to finish beats that give none.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_map(int unsigned w, int unsigned h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_wdata <= MAPH_W'(w);
    @(posedge clk);
    board.write_reg(CFG_MAP_WIDTH, w);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_wdata <= MAPH_W'(h);
    @(posedge clk);
    board.write_reg(CFG_MAP_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_height(int style, int unsigned idx, logic [7:0] base);
    case (style)
      0: return 8'($urandom);
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'(base + $urandom_range(0, 6) + idx % 3);
      default: return base;
    endcase
  endfunction

  // One map in raster order followed by its drain beats. Now and then the map or its drains
  // are cut short, or a stray drain is slipped in, to exercise the restart paths.
  task automatic send_map(int unsigned w, int unsigned h, int unsigned cap);
    int unsigned n, cut, drains, style;
    logic [7:0] base;
    n = w * h;
    cut = n;
    drains = w + 1;
    style = $urandom_range(0, 3);
    base = 8'($urandom);
    if (n > cap) begin
      cut = cap;
      drains = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) cut = $urandom_range(1, n);
      else drains = $urandom_range(0, w);
    end
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) == 0) send_beat(1'b1, 8'($urandom));
      send_beat(1'b0, pick_height(style, i, base));
    end
    if (cut == n) begin
      for (int unsigned i = 0; i < drains; i++) send_beat(1'b1, 8'($urandom));
      if ($urandom_range(0, 4) == 0) send_beat(1'b1, 8'($urandom));
    end
  endtask

  // Receiver: random ready gaps, and once a long hold-off so that the block fills up.
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = (normals_seen == 150) ? 700 : $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0 && normals_seen != 150) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_beat(out_normal_x, out_normal_y, out_normal_z, out_last_of_frame);
      normals_seen++;
    end
  end

  initial begin
    board.clear_all();
    beats_sent = 0;
    calm_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A single-pixel map gives a zero normal flagged as last.
    set_map(1, 1);
    send_beat(1'b0, 8'd0);
    send_beat(1'b1, 8'd0);
    send_beat(1'b1, 8'd0);
    // A drain with nothing due gives nothing.
    send_beat(1'b1, 8'hFF);
    // Single-row map: the first drain releases nothing, the rest give the row.
    set_map(3, 1);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    for (int i = 0; i < 4; i++) send_beat(1'b1, 8'h00);
    // Full-range heights on a 3x3 map; a sample while drains are due drops the rest.
    set_map(3, 3);
    for (int i = 0; i < 9; i++) send_beat(1'b0, (i % 2) ? 8'hFF : 8'h00);
    send_beat(1'b1, 8'h00);
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'h80);

    // Extreme sizes: the widest and the tallest maps, all cut short.
    set_map(1024, 1);
    send_map(1024, 1, 600);
    set_map(1, 65535);
    send_map(1, 65535, 60);
    set_map(1024, 65535);
    send_map(1024, 65535, 40);
    set_map(2, 2);
    send_map(2, 2, 400);
    // The sender stops until everything has drained.
    wait_idle();

    // Random part: mostly small maps, a few larger ones.
    while (beats_sent < ITEM_GOAL) begin
      int unsigned w, h, maps;
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 8);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 19) == 0) h = $urandom_range(1000, 65535);
      set_map(w, h);
      maps = $urandom_range(1, 3);
      for (int m = 0; m < maps; m++) send_map(w, h, 300);
    end

    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("heightmap_normal_generator_core regression: pass");
    end else begin
      $display("heightmap_normal_generator_core regression: fail");
    end
    $finish;
  end
endmodule
